### hw/rtl/tdp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Type descriptor parser package
// Shared widths, character constants, result codes, the queue entry and the
// result record, and the byte classifier used by the front end.
// ----------------------------------------------------------------------------
package tdp_pkg;

    localparam int CHAR_W = 8;
    localparam int DIM_W  = 8;
    localparam int TYPE_W = 4;

    // Descriptor characters that steer the parse.
    localparam logic [CHAR_W-1:0] CH_BRACKET = 8'h5B;  // '['
    localparam logic [CHAR_W-1:0] CH_OBJECT  = 8'h4C;  // 'L'
    localparam logic [CHAR_W-1:0] CH_SEMI    = 8'h3B;  // ';'
    localparam logic [CHAR_W-1:0] CH_SLASH   = 8'h2F;  // '/'
    localparam logic [CHAR_W-1:0] CH_DOT     = 8'h2E;  // '.'
    localparam logic [CHAR_W-1:0] CH_OPEN    = 8'h28;  // '('
    localparam logic [CHAR_W-1:0] CH_CLOSE   = 8'h29;  // ')'
    localparam logic [CHAR_W-1:0] CH_VOID    = 8'h56;  // 'V'
    localparam logic [CHAR_W-1:0] CH_BYTE    = 8'h42;  // 'B'
    localparam logic [CHAR_W-1:0] CH_CHAR    = 8'h43;  // 'C'
    localparam logic [CHAR_W-1:0] CH_DOUBLE  = 8'h44;  // 'D'
    localparam logic [CHAR_W-1:0] CH_FLOAT   = 8'h46;  // 'F'
    localparam logic [CHAR_W-1:0] CH_INT     = 8'h49;  // 'I'
    localparam logic [CHAR_W-1:0] CH_LONG    = 8'h4A;  // 'J'
    localparam logic [CHAR_W-1:0] CH_SHORT   = 8'h53;  // 'S'
    localparam logic [CHAR_W-1:0] CH_BOOL    = 8'h5A;  // 'Z'

    // Type codes of a completed type.
    localparam logic [TYPE_W-1:0] TC_BYTE   = 4'd0;
    localparam logic [TYPE_W-1:0] TC_CHAR   = 4'd1;
    localparam logic [TYPE_W-1:0] TC_DOUBLE = 4'd2;
    localparam logic [TYPE_W-1:0] TC_FLOAT  = 4'd3;
    localparam logic [TYPE_W-1:0] TC_INT    = 4'd4;
    localparam logic [TYPE_W-1:0] TC_LONG   = 4'd5;
    localparam logic [TYPE_W-1:0] TC_SHORT  = 4'd6;
    localparam logic [TYPE_W-1:0] TC_BOOL   = 4'd7;
    localparam logic [TYPE_W-1:0] TC_VOID   = 4'd8;
    localparam logic [TYPE_W-1:0] TC_OBJECT = 4'd9;

    typedef enum logic [1:0] {
        EV_CONSUMED = 2'd0,
        EV_NAME     = 2'd1,
        EV_TYPE     = 2'd2,
        EV_ERROR    = 2'd3
    } event_t;

    typedef enum logic [2:0] {
        ERR_NONE         = 3'd0,
        ERR_BAD_LETTER   = 3'd1,
        ERR_VOID_ARRAY   = 3'd2,
        ERR_NO_PAREN     = 3'd3,
        ERR_TRUNCATED    = 3'd4,
        ERR_DIM_OVERFLOW = 3'd5
    } error_t;

    typedef enum logic [2:0] {
        CLS_OTHER,
        CLS_BRACKET,
        CLS_OBJECT,
        CLS_SEMI,
        CLS_OPEN,
        CLS_CLOSE,
        CLS_VOID,
        CLS_BASE
    } char_class_t;

    // One classified byte as it waits between the front and back ends.
    typedef struct packed {
        logic                start;
        char_class_t         cls;
        logic [TYPE_W-1:0]   base;
        logic [CHAR_W-1:0]   name_byte;
    } item_t;

    // One result as it leaves the block.
    typedef struct packed {
        event_t              ev;
        logic [TYPE_W-1:0]   type_code;
        logic [DIM_W-1:0]    dims;
        logic [CHAR_W-1:0]   name_char;
        logic                is_return;
        logic                done;
        error_t              err;
    } result_t;

    // Sorts a byte into the class the parser acts on and prepares its
    // class-name form, with slash turned into dot.
    function automatic item_t classify(input logic [CHAR_W-1:0] c, input logic start);
        item_t it;
        it.start     = start;
        it.cls       = CLS_OTHER;
        it.base      = TC_BYTE;
        it.name_byte = (c == CH_SLASH) ? CH_DOT : c;
        unique case (c)
            CH_BRACKET: it.cls = CLS_BRACKET;
            CH_OBJECT:  it.cls = CLS_OBJECT;
            CH_SEMI:    it.cls = CLS_SEMI;
            CH_OPEN:    it.cls = CLS_OPEN;
            CH_CLOSE:   it.cls = CLS_CLOSE;
            CH_VOID:    it.cls = CLS_VOID;
            CH_BYTE:    begin it.cls = CLS_BASE; it.base = TC_BYTE;   end
            CH_CHAR:    begin it.cls = CLS_BASE; it.base = TC_CHAR;   end
            CH_DOUBLE:  begin it.cls = CLS_BASE; it.base = TC_DOUBLE; end
            CH_FLOAT:   begin it.cls = CLS_BASE; it.base = TC_FLOAT;  end
            CH_INT:     begin it.cls = CLS_BASE; it.base = TC_INT;    end
            CH_LONG:    begin it.cls = CLS_BASE; it.base = TC_LONG;   end
            CH_SHORT:   begin it.cls = CLS_BASE; it.base = TC_SHORT;  end
            CH_BOOL:    begin it.cls = CLS_BASE; it.base = TC_BOOL;   end
            default:    it.cls = CLS_OTHER;
        endcase
        return it;
    endfunction

endpackage : tdp_pkg
`default_nettype wire

### hw/rtl/tdp_desc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Descriptor byte channel
// Carries one descriptor byte and its start mark per beat, valid/ready.
// ----------------------------------------------------------------------------
interface tdp_desc_if;

    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       start_req;

    modport source (output valid, output char_in, output start_req, input ready);
    modport sink   (input valid, input char_in, input start_req, output ready);

endinterface : tdp_desc_if
`default_nettype wire

### hw/rtl/tdp_result_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Parse result channel
// Carries one parse result per beat, valid/ready.
// ----------------------------------------------------------------------------
interface tdp_result_if;

    logic       valid;
    logic       ready;
    logic [1:0] event_res;
    logic [3:0] type_code;
    logic [7:0] array_dims;
    logic [7:0] name_char;
    logic       is_return;
    logic       done_res;
    logic [2:0] error_code;

    modport source (
        output valid, output event_res, output type_code, output array_dims,
        output name_char, output is_return, output done_res, output error_code,
        input  ready
    );
    modport sink (
        input  valid, input event_res, input type_code, input array_dims,
        input  name_char, input is_return, input done_res, input error_code,
        output ready
    );

endinterface : tdp_result_if
`default_nettype wire

### hw/rtl/tdp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Type descriptor parser front end
// Accepts descriptor bytes, classifies each one and holds it in a two-entry
// queue until the back end takes it.
// ----------------------------------------------------------------------------
module tdp_front
    import tdp_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    tdp_desc_if.sink    desc,
    output item_t       q_item,
    output logic        q_valid,
    input  wire logic   q_pop
);

    item_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;

    // The queue takes a beat whenever a slot is free.
    assign desc.ready = (count_reg != 2'd2);
    assign push       = desc.valid && desc.ready;

    assign q_valid = (count_reg != 2'd0);
    assign q_item  = entry_reg[rd_ptr_reg];

    // Occupancy follows pushes and pops.
    always_comb
    begin
        count_next = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (q_pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    // Classified bytes are written into the slot under the write pointer.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= classify(desc.char_in, desc.start_req);
        end
    end

endmodule : tdp_front
`default_nettype wire

### hw/rtl/tdp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Type descriptor parser back end
// Runs the descriptor grammar on classified bytes from the queue and holds
// each result in an output register until the receiver takes it.
// ----------------------------------------------------------------------------
module tdp_back
    import tdp_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   cfg_we,
    input  wire logic   cfg_wdata,
    input  item_t       q_item,
    input  wire logic   q_valid,
    output logic        q_pop,
    tdp_result_if.source result
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PAREN,
        PH_TYPE,
        PH_NAME
    } phase_t;

    phase_t             phase_reg;
    phase_t             phase_next;
    logic [DIM_W-1:0]   dim_reg;
    logic [DIM_W-1:0]   dim_next;
    logic               ret_reg;
    logic               ret_next;
    logic               mode_reg;
    logic               out_valid_reg;
    result_t            res_reg;
    result_t            res_next;
    logic               fin;
    logic [TYPE_W-1:0]  fin_code;
    logic               fin_done;
    logic               err_set;
    error_t             err_code;

    // A byte is taken whenever the output register is free or being emptied.
    assign q_pop = q_valid && (!out_valid_reg || result.ready);

    // Grammar step for the byte at the head of the queue.
    always_comb
    begin
        phase_next = phase_reg;
        dim_next   = dim_reg;
        ret_next   = ret_reg;
        res_next   = '0;
        fin        = 1'b0;
        fin_code   = TC_BYTE;
        fin_done   = 1'b0;
        err_set    = 1'b0;
        err_code   = ERR_NONE;

        if (q_item.start)
        begin
            if (phase_reg != PH_IDLE)
            begin
                // A new start cuts the descriptor in progress short.
                err_set  = 1'b1;
                err_code = ERR_TRUNCATED;
            end
            else
            begin
                dim_next   = '0;
                ret_next   = 1'b0;
                phase_next = mode_reg ? PH_PAREN : PH_TYPE;
            end
        end

        if (!err_set)
        begin
            unique case (phase_next)
                PH_PAREN:
                begin
                    if (q_item.cls == CLS_OPEN)
                    begin
                        phase_next = PH_TYPE;
                    end
                    else
                    begin
                        err_set  = 1'b1;
                        err_code = ERR_NO_PAREN;
                    end
                end
                PH_TYPE:
                begin
                    case (q_item.cls)
                        CLS_BRACKET:
                        begin
                            if (dim_next == {DIM_W{1'b1}})
                            begin
                                err_set  = 1'b1;
                                err_code = ERR_DIM_OVERFLOW;
                            end
                            else
                            begin
                                dim_next = dim_next + 1'b1;
                            end
                        end
                        CLS_CLOSE:
                        begin
                            if (mode_reg && !ret_next && (dim_next == '0))
                            begin
                                ret_next = 1'b1;
                            end
                            else
                            begin
                                err_set  = 1'b1;
                                err_code = ERR_BAD_LETTER;
                            end
                        end
                        CLS_VOID:
                        begin
                            if (dim_next != '0)
                            begin
                                err_set  = 1'b1;
                                err_code = ERR_VOID_ARRAY;
                            end
                            else
                            begin
                                fin      = 1'b1;
                                fin_code = TC_VOID;
                            end
                        end
                        CLS_OBJECT:
                        begin
                            phase_next = PH_NAME;
                        end
                        CLS_BASE:
                        begin
                            fin      = 1'b1;
                            fin_code = q_item.base;
                        end
                        default:
                        begin
                            err_set  = 1'b1;
                            err_code = ERR_BAD_LETTER;
                        end
                    endcase
                end
                PH_NAME:
                begin
                    if (q_item.cls == CLS_SEMI)
                    begin
                        fin      = 1'b1;
                        fin_code = TC_OBJECT;
                    end
                    else
                    begin
                        res_next.ev        = EV_NAME;
                        res_next.name_char = q_item.name_byte;
                    end
                end
                default:
                begin
                    // Idle byte without a start mark is consumed silently.
                end
            endcase
        end

        // Completed type: report it and move to the next type or finish.
        if (fin)
        begin
            fin_done           = !mode_reg || ret_next;
            res_next.ev        = EV_TYPE;
            res_next.type_code = fin_code;
            res_next.dims      = dim_next;
            res_next.is_return = mode_reg && ret_next;
            res_next.done      = fin_done;
            dim_next           = '0;
            if (fin_done)
            begin
                phase_next = PH_IDLE;
                ret_next   = 1'b0;
            end
            else
            begin
                phase_next = PH_TYPE;
            end
        end

        // Any error drops the parse state back to idle.
        if (err_set)
        begin
            res_next      = '0;
            res_next.ev   = EV_ERROR;
            res_next.err  = err_code;
            phase_next    = PH_IDLE;
            dim_next      = '0;
            ret_next      = 1'b0;
        end
    end

    // Parser state, mode register and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            dim_reg       <= '0;
            ret_reg       <= 1'b0;
            mode_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            if (q_pop)
            begin
                phase_reg     <= phase_next;
                dim_reg       <= dim_next;
                ret_reg       <= ret_next;
                res_reg       <= res_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.event_res  = res_reg.ev;
    assign result.type_code  = res_reg.type_code;
    assign result.array_dims = res_reg.dims;
    assign result.name_char  = res_reg.name_char;
    assign result.is_return  = res_reg.is_return;
    assign result.done_res   = res_reg.done;
    assign result.error_code = res_reg.err;

endmodule : tdp_back
`default_nettype wire

### hw/rtl/type_descriptor_parser_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Type descriptor parser unit
// Streaming parser for field and method type descriptors, one byte per beat.
//
// The desc channel takes one descriptor byte per beat together with start_req,
// which marks the first byte of a new descriptor. Every byte gives exactly
// one beat on the result channel: byte consumed, class-name byte (slash shown
// as dot), completed type with its dimensions and return flag, or an error.
// The done_res flag marks the result that ends the whole descriptor; after
// it, or after an error, bytes are ignored until the next start.
// cfg_we with cfg_wdata sets method mode (1) or field mode (0); write it only
// while no bytes are in flight.
// An accepted byte passes through the two-entry classification queue and then
// the output register before its result appears. Throughput is one byte per
// cycle while the receiver takes results, set by the combinational grammar step
// in the back end. Reset clears the queue, the parse state and field mode.
// When the receiver stalls, the result is held and the queue fills both of its
// entries before desc.ready drops.
// ----------------------------------------------------------------------------
module type_descriptor_parser_unit
    import tdp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    cfg_we,
    input  wire logic    cfg_wdata,
    tdp_desc_if.sink     desc,
    tdp_result_if.source result
);

    item_t q_item;
    logic  q_valid;
    logic  q_pop;

    // Classification and queueing.
    tdp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .desc    (desc),
        .q_item  (q_item),
        .q_valid (q_valid),
        .q_pop   (q_pop)
    );

    // Grammar and result register.
    tdp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_item    (q_item),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .result    (result)
    );

endmodule : type_descriptor_parser_unit
`default_nettype wire

### hw/rtl/tdp_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Type descriptor parser checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module tdp_checker
    import tdp_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [1:0] event_res,
    input wire logic [3:0] type_code,
    input wire logic [7:0] array_dims,
    input wire logic       is_return,
    input wire logic       done_res,
    input wire logic [2:0] error_code
);

    // A result that is not taken stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn while stalled");

    // An error carries a non-zero code and never ends a descriptor.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == EV_ERROR) |-> (error_code != ERR_NONE) && !done_res)
        else $error("malformed error result");

    // Only error results carry an error code.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res != EV_ERROR) |-> (error_code == ERR_NONE))
        else $error("error code on a non-error result");

    // Return flag, done flag and type fields belong to completed types only.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res != EV_TYPE)
        |-> !is_return && !done_res && (type_code == TC_BYTE) && (array_dims == '0))
        else $error("type fields on a non-type result");

endmodule : tdp_checker

bind type_descriptor_parser_unit tdp_checker u_tdp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .event_res  (result.event_res),
    .type_code  (result.type_code),
    .array_dims (result.array_dims),
    .is_return  (result.is_return),
    .done_res   (result.done_res),
    .error_code (result.error_code)
);
`default_nettype wire
